[rtl/lru_write_back_block_cache_ctrl_unit_defines.svh]
// assertion helpers shared by the cache controller modules
`ifndef LRU_WRITE_BACK_BLOCK_CACHE_CTRL_UNIT_DEFINES_SVH
`define LRU_WRITE_BACK_BLOCK_CACHE_CTRL_UNIT_DEFINES_SVH

// same-cycle implication
`define LWBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LWBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lwbc_pkg.sv]
package lwbc_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int SLOT_OUT_W = 4;
    localparam int BLK_W      = 32;
    localparam int OFF_W      = 16;
    localparam int LEN_W      = 17;
    localparam int BS_W       = 17;

    localparam logic [BS_W-1:0] BLOCK_SIZE_RST = 17'd512;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_WIPE  = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    typedef struct packed {
        logic load_req;
        logic scan_start;
        logic scan_issue;
        logic flush_read;
        logic flush_skip;
        logic flush_emit;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_flush;
        logic idx_end;
        logic idx_last;
        logic slot_vd;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/lwbc_ctrl.sv]
`include "lru_write_back_block_cache_ctrl_unit_defines.svh"

module lwbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lwbc_pkg::t_dp_sts i_sts,
    output lwbc_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_L_SCAN,
        ST_L_DRAIN,
        ST_L_COMMIT,
        ST_F_SCAN,
        ST_F_READ
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req   = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state = i_sts.in_flush ? ST_F_SCAN : ST_L_SCAN;
                end
            end
            ST_L_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = ST_L_DRAIN;
                end
            end
            ST_L_DRAIN: begin
                // last tag compare lands this cycle
                n_state = ST_L_COMMIT;
            end
            ST_L_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_F_SCAN: begin
                if (i_sts.idx_end) begin
                    n_state = ST_IDLE;
                end else if (i_sts.slot_vd) begin
                    o_cmd.flush_read = 1'b1;
                    n_state = ST_F_READ;
                end else begin
                    o_cmd.flush_skip = 1'b1;
                end
            end
            ST_F_READ: begin
                if (i_sts.out_free) begin
                    o_cmd.flush_emit = 1'b1;
                    n_state = ST_F_SCAN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    `LWBC_ASSERT_IMP(a_no_issue_past_end, i_clk, i_rst_n, i_sts.idx_end, !o_cmd.scan_issue && !o_cmd.flush_read, "slot read issued past the last slot")

endmodule

[rtl/lwbc_dp.sv]
`include "lru_write_back_block_cache_ctrl_unit_defines.svh"

module lwbc_dp #(
    parameter int SLOTS = lwbc_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lwbc_pkg::BS_W-1:0]       i_cfg_wdata,
    input  logic [1:0]                      i_operation,
    input  logic [lwbc_pkg::BLK_W-1:0]      i_block_number,
    input  logic [lwbc_pkg::OFF_W-1:0]      i_offset,
    input  logic [lwbc_pkg::LEN_W-1:0]      i_length,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_status,
    output logic                            o_hit,
    output logic [lwbc_pkg::SLOT_OUT_W-1:0] o_slot,
    output logic                            o_writeback_needed,
    output logic [lwbc_pkg::BLK_W-1:0]      o_writeback_block,
    output logic                            o_fetch_needed,
    output logic                            o_clear_slot,
    output logic                            o_last,
    input  lwbc_pkg::t_dp_cmd               i_cmd,
    output lwbc_pkg::t_dp_sts               o_sts
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IDX_W  = $clog2(SLOTS + 1);
    localparam int SUM_W  = lwbc_pkg::LEN_W + 1;
    localparam logic [SLOT_W-1:0] AGE_MAX = SLOT_W'(SLOTS - 1);

    // configuration and request
    logic [lwbc_pkg::BS_W-1:0]  r_block_size;
    lwbc_pkg::t_op              r_op;
    logic [lwbc_pkg::BLK_W-1:0] r_blk;
    logic [lwbc_pkg::OFF_W-1:0] r_off;
    logic [lwbc_pkg::LEN_W-1:0] r_len;

    // slot state
    logic [lwbc_pkg::BLK_W-1:0] r_tag_mem [SLOTS];
    logic [lwbc_pkg::BLK_W-1:0] r_rd_data;
    logic [SLOTS-1:0]           r_valid;
    logic [SLOTS-1:0]           r_dirty;
    logic [SLOT_W-1:0]          r_age [SLOTS];

    // scan pointer and compare stage
    logic [IDX_W-1:0]  r_idx;
    logic              r_cmp_vld;
    logic [SLOT_W-1:0] r_cmp_idx;

    // search results
    logic                       r_found;
    logic [SLOT_W-1:0]          r_hit_slot;
    logic [SLOT_W-1:0]          r_hit_age;
    logic                       r_free_found;
    logic [SLOT_W-1:0]          r_free_slot;
    logic                       r_old_any;
    logic [SLOT_W-1:0]          r_old_slot;
    logic [SLOT_W-1:0]          r_old_age;
    logic                       r_old_dirty;
    logic [lwbc_pkg::BLK_W-1:0] r_old_tag;

    // output register
    logic                            r_out_vld;
    logic                            r_out_status;
    logic                            r_out_hit;
    logic [lwbc_pkg::SLOT_OUT_W-1:0] r_out_slot;
    logic                            r_out_wb;
    logic [lwbc_pkg::BLK_W-1:0]      r_out_wb_block;
    logic                            r_out_fetch;
    logic                            r_out_clear;
    logic                            r_out_last;

    logic [SLOT_W-1:0]     idx_slot;
    logic                  idx_end;
    logic                  out_free;
    logic                  cmp_valid;
    logic [SLOT_W-1:0]     cmp_age;
    logic                  cmp_dirty;
    logic [SLOT_W-1:0]     sel_slot;
    logic [SLOT_W-1:0]     sel_age;
    logic                  bump_all;
    logic [SUM_W-1:0]      acc_end;
    logic                  oob;
    logic                  set_dirty;
    logic                  evict_wb;
    logic                  mem_re;
    logic                  mem_we;
    logic [SLOTS-1:0]      idx_onehot;
    logic                  flush_last;
    logic [SLOT_W+3:0]     sel_ext;
    logic [SLOT_W+3:0]     idx_ext;

    assign idx_slot = r_idx[SLOT_W-1:0];
    assign idx_end  = (r_idx == IDX_W'(SLOTS));
    assign out_free = !r_out_vld || !i_out_stall;

    assign o_sts.in_flush = (i_operation == lwbc_pkg::OP_FLUSH);
    assign o_sts.idx_end  = idx_end;
    assign o_sts.idx_last = (r_idx == IDX_W'(SLOTS - 1));
    assign o_sts.slot_vd  = !idx_end && r_valid[idx_slot] && r_dirty[idx_slot];
    assign o_sts.out_free = out_free;

    assign cmp_valid = r_valid[r_cmp_idx];
    assign cmp_age   = r_age[r_cmp_idx];
    assign cmp_dirty = r_dirty[r_cmp_idx];

    always_comb begin
        // hit first, then the lowest free slot, else evict the oldest
        if (r_found) begin
            sel_slot = r_hit_slot;
        end else if (r_free_found) begin
            sel_slot = r_free_slot;
        end else begin
            sel_slot = r_old_slot;
        end
        sel_age  = r_found ? r_hit_age : r_old_age;
        bump_all = !r_found && r_free_found;
        evict_wb = !r_found && !r_free_found && r_old_dirty;

        // a wipe covers the whole block and never runs past the end
        acc_end   = SUM_W'(r_off) + SUM_W'(r_len);
        oob       = (r_op != lwbc_pkg::OP_WIPE) && (acc_end > SUM_W'(r_block_size));
        set_dirty = !oob && (r_op != lwbc_pkg::OP_READ);

        idx_onehot           = '0;
        idx_onehot[idx_slot] = 1'b1;
        flush_last = ((r_valid & r_dirty & ~idx_onehot) == '0);

        sel_ext = {4'b0000, sel_slot};
        idx_ext = {4'b0000, idx_slot};
    end

    assign mem_re = i_cmd.scan_issue || i_cmd.flush_read;
    assign mem_we = i_cmd.commit && !r_found;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tag_mem[sel_slot] <= r_blk;
        end
        if (mem_re) begin
            r_rd_data <= r_tag_mem[idx_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op  <= lwbc_pkg::t_op'(i_operation);
            r_blk <= i_block_number;
            r_off <= i_offset;
            r_len <= i_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= lwbc_pkg::BLOCK_SIZE_RST;
            r_valid      <= '0;
            r_dirty      <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_block_size <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (SLOT_W'(i) == sel_slot) begin
                        r_age[i] <= '0;
                    end else if (r_valid[i] &&
                                 (bump_all ? (r_age[i] < AGE_MAX) : (r_age[i] < sel_age))) begin
                        r_age[i] <= r_age[i] + SLOT_W'(1);
                    end
                end
                r_valid[sel_slot] <= 1'b1;
                if (!r_found || set_dirty) begin
                    r_dirty[sel_slot] <= set_dirty;
                end
            end
            if (i_cmd.flush_emit) begin
                r_dirty[idx_slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_old_any    <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_idx <= '0;
            end else if (i_cmd.scan_issue || i_cmd.flush_skip || i_cmd.flush_emit) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            r_cmp_vld <= i_cmd.scan_issue;
            if (i_cmd.scan_issue) begin
                r_cmp_idx <= idx_slot;
            end

            if (i_cmd.scan_start) begin
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
                r_old_any    <= 1'b0;
            end else if (r_cmp_vld) begin
                if (cmp_valid && (r_rd_data == r_blk) && !r_found) begin
                    r_found    <= 1'b1;
                    r_hit_slot <= r_cmp_idx;
                    r_hit_age  <= cmp_age;
                end
                if (!cmp_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_slot  <= r_cmp_idx;
                end
                if (cmp_valid && (!r_old_any || (cmp_age > r_old_age))) begin
                    r_old_any   <= 1'b1;
                    r_old_slot  <= r_cmp_idx;
                    r_old_age   <= cmp_age;
                    r_old_dirty <= cmp_dirty;
                    r_old_tag   <= r_rd_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit || i_cmd.flush_emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status   <= oob;
            r_out_hit      <= r_found;
            r_out_slot     <= sel_ext[lwbc_pkg::SLOT_OUT_W-1:0];
            r_out_wb       <= evict_wb;
            r_out_wb_block <= evict_wb ? r_old_tag : '0;
            r_out_fetch    <= !r_found;
            r_out_clear    <= (r_op == lwbc_pkg::OP_WIPE) && !oob;
            r_out_last     <= 1'b1;
        end else if (i_cmd.flush_emit) begin
            r_out_status   <= 1'b0;
            r_out_hit      <= 1'b0;
            r_out_slot     <= idx_ext[lwbc_pkg::SLOT_OUT_W-1:0];
            r_out_wb       <= 1'b1;
            r_out_wb_block <= r_rd_data;
            r_out_fetch    <= 1'b0;
            r_out_clear    <= 1'b0;
            r_out_last     <= flush_last;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_status           = r_out_status;
    assign o_hit              = r_out_hit;
    assign o_slot             = r_out_slot;
    assign o_writeback_needed = r_out_wb;
    assign o_writeback_block  = r_out_wb_block;
    assign o_fetch_needed     = r_out_fetch;
    assign o_clear_slot       = r_out_clear;
    assign o_last             = r_out_last;

    `LWBC_ASSERT_IMP(a_load_needs_room, i_clk, i_rst_n, i_cmd.commit || i_cmd.flush_emit, out_free, "result loaded over an untaken one")
    `LWBC_ASSERT_IMP(a_evict_only_full, i_clk, i_rst_n, i_cmd.commit && !r_found && !r_free_found, &r_valid, "eviction while a slot is free")
    `LWBC_ASSERT_NXT(a_commit_newest, i_clk, i_rst_n, i_cmd.commit, r_valid[$past(sel_slot)] && (r_age[$past(sel_slot)] == '0), "chosen slot not valid and newest")
    `LWBC_ASSERT_NXT(a_flush_cleans, i_clk, i_rst_n, i_cmd.flush_emit, !r_dirty[$past(idx_slot)], "flushed slot still dirty")

endmodule

[rtl/lru_write_back_block_cache_ctrl_unit.sv]
// tag and lru replacement controller for a write-back cache of disk blocks
// input channel: i_in_valid / o_in_stall carry one request (read, write,
//   wipe or flush); a transfer happens when valid is high and stall is low
// output channel: o_out_valid / i_out_stall carry result items from an
//   output register; a read, write or wipe gives one result with o_last set,
//   a flush gives one write-back result per dirty slot (none if all clean)
// config: i_cfg_we writes i_cfg_wdata into the block size; the user must do
//   this only while idle, as the block itself does not enforce it
// lookup: the tag memory is read one slot per cycle, then the last compare
//   drains and the result enters the output register once it is free
// flush: walks all slots, emitting each dirty one once the output is free
// one request is in work at a time; the next transfer is taken once the
//   controller is idle, even if the receiver has not yet taken the result
// a stalled receiver holds the output register; the controller waits before
//   loading the next result, so nothing is dropped
// reset (synchronous, active low) marks every slot empty and clean, sets the
//   block size to 512 and empties the output register; no clearing pass
module lru_write_back_block_cache_ctrl_unit #(
    parameter int SLOTS = lwbc_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lwbc_pkg::BS_W-1:0]       i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_operation,
    input  logic [lwbc_pkg::BLK_W-1:0]      i_block_number,
    input  logic [lwbc_pkg::OFF_W-1:0]      i_offset,
    input  logic [lwbc_pkg::LEN_W-1:0]      i_length,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_status,
    output logic                            o_hit,
    output logic [lwbc_pkg::SLOT_OUT_W-1:0] o_slot,
    output logic                            o_writeback_needed,
    output logic [lwbc_pkg::BLK_W-1:0]      o_writeback_block,
    output logic                            o_fetch_needed,
    output logic                            o_clear_slot,
    output logic                            o_last
);

    lwbc_pkg::t_dp_cmd dp_cmd;
    lwbc_pkg::t_dp_sts dp_sts;

    lwbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    lwbc_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_operation        (i_operation),
        .i_block_number     (i_block_number),
        .i_offset           (i_offset),
        .i_length           (i_length),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_hit              (o_hit),
        .o_slot             (o_slot),
        .o_writeback_needed (o_writeback_needed),
        .o_writeback_block  (o_writeback_block),
        .o_fetch_needed     (o_fetch_needed),
        .o_clear_slot       (o_clear_slot),
        .o_last             (o_last),
        .i_cmd              (dp_cmd),
        .o_sts              (dp_sts)
    );

endmodule
